// ===== design/sasbs_pkg.sv =====
// Shared types, constants and register codes of the spectrum AGC smoother.
package sasbs_pkg;

    localparam int BINS   = 1024;
    localparam int ADDR_W = $clog2(BINS);
    localparam int FILL_W = ADDR_W + 1;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic [41:0] SAT42     = 42'h3FF_FFFF_FFFF;
    localparam logic [16:0] UNITY_Q16 = 17'h1_0000;

    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_PEAK_FLR  = 2'd1;
    localparam logic [1:0] CFG_PEAK_DEC  = 2'd2;
    localparam logic [1:0] CFG_BIN_SMOOTH = 2'd3;

    localparam logic [31:0] RST_PEAK_FLR  = 32'd65536;
    localparam logic [15:0] RST_PEAK_DEC  = 16'd62259;
    localparam logic [15:0] RST_BIN_SMOOTH = 16'd39322;

    // Each store entry holds all four views of one bin.
    typedef struct packed {
        logic [31:0] raw_mag;
        logic [31:0] norm_mag;
        logic [31:0] raw_avg;
        logic [31:0] norm_avg;
    } t_entry;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_B_SQRE,
        S_B_SQIM,
        S_B_SUM,
        S_B_ROOT,
        S_B_MAG,
        S_B_NORM,
        S_B_RAVG0,
        S_B_RAVG1,
        S_B_NAVG0,
        S_B_NAVG1,
        S_B_WRITE,
        S_F_CMP,
        S_F_SEL,
        S_F_MUL1,
        S_F_SUM,
        S_F_DIV,
        S_F_WAIT,
        S_Q_SETUP,
        S_Q_WALK,
        S_Q_DRAIN,
        S_OUT
    } t_state;

endpackage

// ===== design/sasbs_in_if.sv =====
// Input channel: one spectrum bin or one band query per beat.
interface sasbs_in_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] bin_real;
    logic signed [31:0] bin_imag;
    logic               last_bin;
    logic signed [16:0] band_start;
    logic signed [16:0] band_end;
    logic               use_smoothed;
    logic               use_raw;

    modport source (
        output valid, kind, bin_real, bin_imag, last_bin, band_start, band_end,
               use_smoothed, use_raw,
        input  ready
    );
    modport sink (
        input  valid, kind, bin_real, bin_imag, last_bin, band_start, band_end,
               use_smoothed, use_raw,
        output ready
    );
endinterface

// ===== design/sasbs_out_if.sv =====
// Output channel: one result beat per accepted input beat.
interface sasbs_out_if;
    logic        valid;
    logic        ready;
    logic [41:0] value;
    logic        was_query;
    logic        out_of_range;

    modport source (
        output valid, value, was_query, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, value, was_query, out_of_range,
        output ready
    );
endinterface

// ===== design/sasbs_ram.sv =====
// Generic single-write, single-read memory with registered read data.
module sasbs_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sasbs_iter.sv =====
// Shift-and-subtract unit: 64-bit integer square root or 2^32 / divisor.
module sasbs_iter (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sasbs_pkg::t_iter_ctl  i_ctl,
    input  logic [63:0]           i_rad,
    input  logic [31:0]           i_den,
    output sasbs_pkg::t_iter_stat o_stat,
    output logic [31:0]           o_root,
    output logic [32:0]           o_quot
);

    logic [63:0] r_rem;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_div;
    logic        r_busy;
    logic        r_done;

    logic [63:0] trial;
    logic [32:0] shifted;

    assign trial   = r_res + r_bit;
    assign shifted = {r_rem[31:0], (r_cnt == 6'd32)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div <= i_ctl.is_div;
            r_res <= '0;
            r_bit <= 64'd1 << 62;
            r_den <= i_den;
            if (i_ctl.is_div) begin
                r_rem <= '0;
                r_cnt <= 6'd32;
            end else begin
                r_rem <= i_rad;
                r_cnt <= 6'd31;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_div) begin
                if (shifted >= {1'b0, r_den}) begin
                    r_rem <= 64'(shifted - {1'b0, r_den});
                    r_res <= {r_res[62:0], 1'b1};
                end else begin
                    r_rem <= 64'(shifted);
                    r_res <= {r_res[62:0], 1'b0};
                end
            end else begin
                if (r_rem >= trial) begin
                    r_rem <= r_rem - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_res[31:0];
    assign o_quot      = r_res[32:0];

endmodule

// ===== design/spectrum_agc_smoother_band_sum.sv =====
// Top level: spectrum magnitude store with peak-following gain and band sums.
// A bin beat takes its magnitude from the square root; the last bin of a frame adds the
// follower update, a decay blend only when the peak falls below the follower, and the
// 33-step reciprocal that gives the new gain.
// A query beat reads one stored bin per cycle across its span; a disabled or fully
// outside query reads none. One beat is in work at a time; a result waits in the output register.
// Synchronous active-low reset; stores read as zero through a fill count, no clearing pass.
module spectrum_agc_smoother_band_sum (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    sasbs_in_if.sink    i_in,
    sasbs_out_if.source o_out
);

    localparam int AW = sasbs_pkg::ADDR_W;
    localparam int FW = sasbs_pkg::FILL_W;
    localparam logic signed [17:0] BINS_S = 18'(sasbs_pkg::BINS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(sasbs_pkg::BINS - 1);

    // Configuration registers.
    logic        r_enable;
    logic [31:0] r_floor;
    logic [15:0] r_decay;
    logic [15:0] r_smooth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_floor  <= sasbs_pkg::RST_PEAK_FLR;
            r_decay  <= sasbs_pkg::RST_PEAK_DEC;
            r_smooth <= sasbs_pkg::RST_BIN_SMOOTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sasbs_pkg::CFG_ENABLE:     r_enable <= i_cfg_data[0];
                sasbs_pkg::CFG_PEAK_FLR:   r_floor  <= i_cfg_data;
                sasbs_pkg::CFG_PEAK_DEC:   r_decay  <= i_cfg_data[15:0];
                sasbs_pkg::CFG_BIN_SMOOTH: r_smooth <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sasbs_pkg::t_state r_state, n_state;

    // Captured beat fields.
    logic               r_kind;
    logic               r_last;
    logic [31:0]        r_re;
    logic [31:0]        r_im;
    logic signed [16:0] r_s;
    logic signed [16:0] r_e;
    logic               r_sm;
    logic               r_raw;

    // Gain loop and frame state.
    logic [31:0]   r_gain;
    logic [31:0]   r_follow;
    logic [31:0]   r_fpeak;
    logic [31:0]   r_p;
    logic [AW-1:0] r_idx;
    logic [FW-1:0] r_fill;

    // Datapath registers around the shared multiplier.
    logic [63:0] r_prod;
    logic [63:0] r_acc;
    logic [31:0] r_m;
    logic [31:0] r_n;
    logic [31:0] r_ravg;
    logic [63:0] r_old;
    logic        r_ok;

    // Query walk.
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_ecl;
    logic          r_rdv;
    logic          r_rdok;
    logic [41:0]   r_sum;
    logic          r_oor;

    // Output register.
    logic        r_ov;
    logic [41:0] r_oval;
    logic        r_owq;
    logic        r_ooor;

    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [AW-1:0]         raddr;
    logic                  we;
    sasbs_pkg::t_entry     wentry;
    sasbs_pkg::t_entry     rentry;
    logic [127:0]          rdata;
    sasbs_pkg::t_iter_ctl  ictl;
    sasbs_pkg::t_iter_stat istat;
    logic [31:0]           root;
    logic [32:0]           quot;
    logic [63:0]           blend_sum;
    logic [32:0]           mag2;
    logic [31:0]           mag_sat;
    logic [31:0]           old_ravg;
    logic [31:0]           old_navg;
    logic [31:0]           peak_sel;
    logic [31:0]           rd_sel;
    logic [42:0]           sum_next;
    logic                  in_acc;
    logic                  out_free;

    // Query range clamping.
    logic signed [17:0] s18;
    logic signed [17:0] e18;
    logic signed [17:0] s_c;
    logic signed [17:0] e_c;
    logic               q_out;

    assign in_acc    = i_in.valid && i_in.ready;
    assign out_free  = !r_ov || o_out.ready;
    assign blend_sum = r_acc + r_prod;
    assign mag2      = {root, 1'b0};
    assign mag_sat   = mag2[32] ? sasbs_pkg::SAT32 : mag2[31:0];
    assign old_ravg  = r_ok ? r_old[63:32] : '0;
    assign old_navg  = r_ok ? r_old[31:0] : '0;
    assign peak_sel  = (r_fpeak > r_floor) ? r_fpeak : r_floor;
    assign rentry    = rdata;

    always_comb begin
        if (r_raw) begin
            rd_sel = r_sm ? rentry.raw_avg : rentry.raw_mag;
        end else begin
            rd_sel = r_sm ? rentry.norm_avg : rentry.norm_mag;
        end
        if (!r_rdok) begin
            rd_sel = '0;
        end
        sum_next = {1'b0, r_sum} + 43'(rd_sel);
    end

    always_comb begin
        s18   = 18'(r_s);
        e18   = 18'(r_e);
        s_c   = s18;
        e_c   = e18;
        q_out = 1'b0;
        if (e18 == -18'sd1) begin
            q_out = (s18 < 18'sd0) || (s18 >= BINS_S);
            e_c   = s18;
        end else begin
            q_out = ((s18 < 18'sd0) && (e18 < 18'sd0)) ||
                    ((s18 >= BINS_S) && (e18 >= BINS_S));
            if (s18 < 18'sd0) begin
                s_c = '0;
            end else if (s18 >= BINS_S) begin
                s_c = BINS_S - 18'sd1;
            end
            if (e18 >= BINS_S) begin
                e_c = BINS_S - 18'sd1;
            end
            if (s_c > e_c) begin
                e_c = s_c;
            end
        end
        if (!r_enable) begin
            q_out = 1'b1;
        end
    end

    // Sequencer: next state and the controls of the multiplier, memory and iterative unit.
    always_comb begin
        n_state     = r_state;
        mul_a       = '0;
        mul_b       = '0;
        raddr       = r_idx;
        we          = 1'b0;
        ictl.start  = 1'b0;
        ictl.is_div = 1'b0;
        case (r_state)
            sasbs_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = i_in.kind ? sasbs_pkg::S_Q_SETUP : sasbs_pkg::S_B_SQRE;
                end
            end
            sasbs_pkg::S_B_SQRE: begin
                mul_a   = r_re;
                mul_b   = r_re;
                n_state = sasbs_pkg::S_B_SQIM;
            end
            sasbs_pkg::S_B_SQIM: begin
                mul_a   = r_im;
                mul_b   = r_im;
                n_state = sasbs_pkg::S_B_SUM;
            end
            sasbs_pkg::S_B_SUM: begin
                ictl.start = 1'b1;
                n_state    = sasbs_pkg::S_B_ROOT;
            end
            sasbs_pkg::S_B_ROOT: begin
                if (istat.done) begin
                    n_state = sasbs_pkg::S_B_MAG;
                end
            end
            sasbs_pkg::S_B_MAG: begin
                n_state = sasbs_pkg::S_B_NORM;
            end
            sasbs_pkg::S_B_NORM: begin
                mul_a   = r_m;
                mul_b   = r_gain;
                n_state = sasbs_pkg::S_B_RAVG0;
            end
            sasbs_pkg::S_B_RAVG0: begin
                mul_a   = old_ravg;
                mul_b   = 32'(r_smooth);
                n_state = sasbs_pkg::S_B_RAVG1;
            end
            sasbs_pkg::S_B_RAVG1: begin
                mul_a   = r_m;
                mul_b   = 32'(sasbs_pkg::UNITY_Q16 - 17'(r_smooth));
                n_state = sasbs_pkg::S_B_NAVG0;
            end
            sasbs_pkg::S_B_NAVG0: begin
                mul_a   = old_navg;
                mul_b   = 32'(r_smooth);
                n_state = sasbs_pkg::S_B_NAVG1;
            end
            sasbs_pkg::S_B_NAVG1: begin
                mul_a   = r_n;
                mul_b   = 32'(sasbs_pkg::UNITY_Q16 - 17'(r_smooth));
                n_state = sasbs_pkg::S_B_WRITE;
            end
            sasbs_pkg::S_B_WRITE: begin
                we      = 1'b1;
                n_state = r_last ? sasbs_pkg::S_F_CMP : sasbs_pkg::S_OUT;
            end
            sasbs_pkg::S_F_CMP: begin
                n_state = sasbs_pkg::S_F_SEL;
            end
            sasbs_pkg::S_F_SEL: begin
                mul_a   = r_follow;
                mul_b   = 32'(r_decay);
                n_state = (r_p < r_follow) ? sasbs_pkg::S_F_MUL1 : sasbs_pkg::S_F_DIV;
            end
            sasbs_pkg::S_F_MUL1: begin
                mul_a   = r_p;
                mul_b   = 32'(sasbs_pkg::UNITY_Q16 - 17'(r_decay));
                n_state = sasbs_pkg::S_F_SUM;
            end
            sasbs_pkg::S_F_SUM: begin
                n_state = sasbs_pkg::S_F_DIV;
            end
            sasbs_pkg::S_F_DIV: begin
                ictl.start  = 1'b1;
                ictl.is_div = 1'b1;
                n_state     = sasbs_pkg::S_F_WAIT;
            end
            sasbs_pkg::S_F_WAIT: begin
                if (istat.done) begin
                    n_state = sasbs_pkg::S_OUT;
                end
            end
            sasbs_pkg::S_Q_SETUP: begin
                n_state = q_out ? sasbs_pkg::S_OUT : sasbs_pkg::S_Q_WALK;
            end
            sasbs_pkg::S_Q_WALK: begin
                raddr = r_i;
                if (r_i == r_ecl) begin
                    n_state = sasbs_pkg::S_Q_DRAIN;
                end
            end
            sasbs_pkg::S_Q_DRAIN: begin
                n_state = sasbs_pkg::S_OUT;
            end
            sasbs_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = sasbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sasbs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sasbs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Shared multiplier with its product register.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Control and gain-loop state that reset clears.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= sasbs_pkg::ONE_Q16;
            r_follow <= sasbs_pkg::ONE_Q16;
            r_fpeak  <= '0;
            r_idx    <= '0;
            r_fill   <= '0;
            r_rdv    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_rdv <= (r_state == sasbs_pkg::S_Q_WALK);
            case (r_state)
                sasbs_pkg::S_B_MAG: begin
                    if (mag_sat > r_fpeak) begin
                        r_fpeak <= mag_sat;
                    end
                end
                sasbs_pkg::S_B_WRITE: begin
                    // Bins are written as a prefix, so the fill count marks every entry that has
                    // not yet been written; reads treat those entries as zero.
                    if ({1'b0, r_idx} == r_fill) begin
                        r_fill <= r_fill + FW'(1);
                    end
                    r_idx <= (r_idx == LAST_ADDR) ? '0 : r_idx + AW'(1);
                end
                sasbs_pkg::S_F_SEL: begin
                    if (r_p > r_follow) begin
                        r_follow <= r_p;
                    end
                end
                sasbs_pkg::S_F_SUM: begin
                    r_follow <= blend_sum[47:16];
                end
                sasbs_pkg::S_F_WAIT: begin
                    if (istat.done) begin
                        r_gain  <= quot[32] ? sasbs_pkg::SAT32 : quot[31:0];
                        r_fpeak <= '0;
                        r_idx   <= '0;
                    end
                end
                default: ;
            endcase
            if (r_state == sasbs_pkg::S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind <= i_in.kind;
            r_last <= i_in.last_bin;
            r_re   <= i_in.bin_real[31] ? 32'(-i_in.bin_real) : 32'(i_in.bin_real);
            r_im   <= i_in.bin_imag[31] ? 32'(-i_in.bin_imag) : 32'(i_in.bin_imag);
            r_s    <= i_in.band_start;
            r_e    <= i_in.band_end;
            r_sm   <= i_in.use_smoothed;
            r_raw  <= i_in.use_raw;
        end
        case (r_state)
            sasbs_pkg::S_B_SQIM: begin
                r_acc <= r_prod;
            end
            sasbs_pkg::S_B_SUM: begin
                r_old <= {rentry.raw_avg, rentry.norm_avg};
                r_ok  <= {1'b0, r_idx} < r_fill;
            end
            sasbs_pkg::S_B_MAG: begin
                r_m <= mag_sat;
            end
            sasbs_pkg::S_B_RAVG0: begin
                r_n <= (r_prod[63:48] != '0) ? sasbs_pkg::SAT32 : r_prod[47:16];
            end
            sasbs_pkg::S_B_RAVG1: begin
                r_acc <= r_prod;
            end
            sasbs_pkg::S_B_NAVG0: begin
                r_ravg <= blend_sum[47:16];
            end
            sasbs_pkg::S_B_NAVG1: begin
                r_acc <= r_prod;
            end
            sasbs_pkg::S_B_WRITE: begin
                r_oor <= 1'b0;
            end
            sasbs_pkg::S_F_CMP: begin
                r_p <= peak_sel;
            end
            sasbs_pkg::S_F_MUL1: begin
                r_acc <= r_prod;
            end
            sasbs_pkg::S_Q_SETUP: begin
                r_oor <= q_out;
                r_sum <= '0;
                r_i   <= s_c[AW-1:0];
                r_ecl <= e_c[AW-1:0];
            end
            sasbs_pkg::S_Q_WALK: begin
                r_i <= r_i + AW'(1);
            end
            default: ;
        endcase
        r_rdok <= {1'b0, r_i} < r_fill;
        if (r_rdv) begin
            r_sum <= sum_next[42] ? sasbs_pkg::SAT42 : sum_next[41:0];
        end
        if (r_state == sasbs_pkg::S_OUT && out_free) begin
            r_oval <= r_kind ? r_sum : 42'(r_n);
            r_owq  <= r_kind;
            r_ooor <= r_kind && r_oor;
        end
    end

    // The new averages go out together with the new magnitudes in one write.
    assign wentry.raw_mag  = r_m;
    assign wentry.norm_mag = r_n;
    assign wentry.raw_avg  = r_ravg;
    assign wentry.norm_avg = blend_sum[47:16];

    sasbs_ram #(
        .WIDTH (128),
        .DEPTH (sasbs_pkg::BINS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_idx),
        .i_wdata (wentry),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    sasbs_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ictl),
        .i_rad   (blend_sum),
        .i_den   (r_follow),
        .o_stat  (istat),
        .o_root  (root),
        .o_quot  (quot)
    );

    // No beat is taken while reset is held.
    assign i_in.ready         = i_rst_n && (r_state == sasbs_pkg::S_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.value        = r_oval;
    assign o_out.was_query    = r_owq;
    assign o_out.out_of_range = r_ooor;

endmodule
